// File: rtl/fsbm_pkg.sv
package fsbm_pkg;

    localparam int MAX_BLOCK = 16;
    localparam int MAX_RANGE = 8;
    localparam int WDIM      = MAX_BLOCK + 2 * MAX_RANGE;

    localparam int T_DEPTH = MAX_BLOCK * MAX_BLOCK;
    localparam int W_DEPTH = WDIM * WDIM;
    localparam int TA_W    = $clog2(T_DEPTH);
    localparam int WA_W    = $clog2(W_DEPTH);
    localparam int CW      = $clog2(WDIM);

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 7;
    localparam int NTAPS     = 9;
    localparam int TAP_W     = 4;
    localparam int RANGE_W   = 4;
    localparam int BLOCK_W   = 5;
    localparam int KERNEL_W  = COEF_W * NTAPS;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = KERNEL_W;
    localparam int VEC_W     = 5;
    localparam int COST_W    = 16;
    localparam int MATCH_W   = 9;

    localparam int SUM_NEED = $clog2(T_DEPTH * 255 + 1);
    localparam int SUM_W    = (SUM_NEED > 17) ? SUM_NEED : 17;
    localparam int MCNT_W   = $clog2(T_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_T,
        ST_EDGE_W,
        ST_DRAIN,
        ST_SEARCH,
        ST_FLUSH
    } state_t;

    function automatic logic [TA_W-1:0] t_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
        int a;
        a = int'(row) * MAX_BLOCK + int'(col);
        return TA_W'(a);
    endfunction

    function automatic logic [WA_W-1:0] w_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
        int a;
        a = int'(row) * WDIM + int'(col);
        return WA_W'(a);
    endfunction

endpackage

// File: rtl/fsbm_ram.sv
module fsbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/full_search_block_matcher.sv
// Channel   Ports                                          Transaction
// config    cfg_we, cfg_index, cfg_data                    cfg_we high at clk edge
// pixel in  start/busy, region, pix_row, pix_col, pixel,   start && !busy
//           last_pixel
// result    done, vec_row, vec_col, sad_cost, edge_cost,   done high for one cycle
//           match_count
//
// A pixel without last_pixel leaves busy low, so the next pixel can follow it directly.
// A pixel with last_pixel keeps busy high through edge images of T*T and W*W pixels
// (one 3x3 tap per cycle through the pixel RAM read port), a drain state, a search of
// (2R+1)^2 candidates of T*T pixels (one pixel per cycle through all four RAMs) and a
// flush state; done is strobed in the same cycle that busy falls. Reset clears control
// state and resets configuration to its defaults; the pixel and edge RAMs are not
// cleared. The result cannot be stalled.
module full_search_block_matcher
    import fsbm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        region,
    input  logic [4:0]                  pix_row,
    input  logic [4:0]                  pix_col,
    input  logic [PIX_W-1:0]            pixel,
    input  logic                        last_pixel,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    output logic                        done,
    output logic signed [VEC_W-1:0]     vec_row,
    output logic signed [VEC_W-1:0]     vec_col,
    output logic [COST_W-1:0]           sad_cost,
    output logic [COST_W-1:0]           edge_cost,
    output logic [MATCH_W-1:0]          match_count
);

    state_t state_reg, state_next;

    logic [RANGE_W-1:0]  range_cfg_reg;
    logic [BLOCK_W-1:0]  block_cfg_reg;
    logic [KERNEL_W-1:0] kernel_reg;

    logic [CW-1:0] tm1_reg, tm1_next;
    logic [CW-1:0] wm1_reg, wm1_next;
    logic [CW-1:0] r2_reg, r2_next;
    logic [CW-1:0] rng_reg, rng_next;

    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    ti_reg, ti_next;
    logic [1:0]    tj_reg, tj_next;
    logic [CW-1:0] dr_reg, dr_next;
    logic [CW-1:0] dc_reg, dc_next;

    // edge pipeline stage
    logic            e_vld_reg, e_vld_next;
    logic            e_win_reg, e_win_next;
    logic [TAP_W-1:0] e_tap_reg, e_tap_next;
    logic            e_last_reg, e_last_next;
    logic            e_bord_reg, e_bord_next;
    logic [WA_W-1:0] e_dst_reg, e_dst_next;
    logic [PIX_W-1:0] acc_reg, acc_next;

    // search pipeline stages
    logic            s_vld_reg, s_vld_next;
    logic            s_first_reg, s_first_next;
    logic            s_last_reg, s_last_next;
    logic            s_final_reg, s_final_next;
    logic [CW-1:0]   s_dr_reg, s_dr_next;
    logic [CW-1:0]   s_dc_reg, s_dc_next;
    logic [SUM_W-1:0]  sad_acc_reg, sad_acc_next;
    logic [SUM_W-1:0]  edg_acc_reg, edg_acc_next;
    logic [MCNT_W-1:0] mat_acc_reg, mat_acc_next;

    logic              cand_vld_reg, cand_vld_next;
    logic              cand_final_reg, cand_final_next;
    logic [SUM_W-1:0]  cand_sad_reg, cand_sad_next;
    logic [SUM_W-1:0]  cand_edg_reg, cand_edg_next;
    logic [MCNT_W-1:0] cand_mat_reg, cand_mat_next;
    logic [CW-1:0]     cand_dr_reg, cand_dr_next;
    logic [CW-1:0]     cand_dc_reg, cand_dc_next;

    logic [SUM_W-1:0]  best_sad_reg, best_sad_next;
    logic [SUM_W-1:0]  best_edg_reg, best_edg_next;
    logic [MCNT_W-1:0] best_mat_reg, best_mat_next;
    logic [CW-1:0]     best_dr_reg, best_dr_next;
    logic [CW-1:0]     best_dc_reg, best_dc_next;

    logic               done_reg, done_next;
    logic [VEC_W-1:0]   vr_reg, vr_next;
    logic [VEC_W-1:0]   vc_reg, vc_next;
    logic [COST_W-1:0]  sad_out_reg, sad_out_next;
    logic [COST_W-1:0]  edg_out_reg, edg_out_next;
    logic [MATCH_W-1:0] mat_out_reg, mat_out_next;

    // RAM ports
    logic             tp_we, wp_we, te_we, we_we;
    logic [TA_W-1:0]  tp_waddr, tp_raddr, te_waddr, te_raddr;
    logic [WA_W-1:0]  wp_waddr, wp_raddr, we_waddr, we_raddr;
    logic [PIX_W-1:0] tp_rdata, wp_rdata, te_rdata, we_rdata, edge_wdata;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    fsbm_ram #(.WIDTH(PIX_W), .DEPTH(T_DEPTH)) u_tpix (
        .clk(clk), .we(tp_we), .waddr(tp_waddr), .wdata(pixel),
        .raddr(tp_raddr), .rdata(tp_rdata));
    fsbm_ram #(.WIDTH(PIX_W), .DEPTH(W_DEPTH)) u_wpix (
        .clk(clk), .we(wp_we), .waddr(wp_waddr), .wdata(pixel),
        .raddr(wp_raddr), .rdata(wp_rdata));
    fsbm_ram #(.WIDTH(PIX_W), .DEPTH(T_DEPTH)) u_tedge (
        .clk(clk), .we(te_we), .waddr(te_waddr), .wdata(edge_wdata),
        .raddr(te_raddr), .rdata(te_rdata));
    fsbm_ram #(.WIDTH(PIX_W), .DEPTH(W_DEPTH)) u_wedge (
        .clk(clk), .we(we_we), .waddr(we_waddr), .wdata(edge_wdata),
        .raddr(we_raddr), .rdata(we_rdata));

    // pixel load
    always_comb
    begin
        tp_we    = accept && !region && (int'(pix_row) < MAX_BLOCK)
                   && (int'(pix_col) < MAX_BLOCK);
        wp_we    = accept && region && (int'(pix_row) < WDIM) && (int'(pix_col) < WDIM);
        tp_waddr = t_addr(CW'(pix_row), CW'(pix_col));
        wp_waddr = w_addr(CW'(pix_row), CW'(pix_col));
    end

    // edge accumulate (low 8 bits only)
    logic signed [COEF_W-1:0]      coef;
    logic signed [COEF_W+PIX_W:0]  prod;
    logic [PIX_W-1:0]              e_pix;
    always_comb
    begin
        e_pix      = e_win_reg ? wp_rdata : tp_rdata;
        coef       = kernel_reg[COEF_W*e_tap_reg +: COEF_W];
        prod       = coef * $signed({1'b0, e_pix});
        acc_next   = ((e_tap_reg == '0) ? '0 : acc_reg) + prod[PIX_W-1:0];
        edge_wdata = e_bord_reg ? '0 : acc_next;
        te_we      = e_vld_reg && e_last_reg && !e_win_reg;
        we_we      = e_vld_reg && e_last_reg && e_win_reg;
        te_waddr   = e_dst_reg[TA_W-1:0];
        we_waddr   = e_dst_reg;
    end

    // candidate accumulate
    logic [PIX_W-1:0] d_pix, d_edg;
    always_comb
    begin
        d_pix = (tp_rdata > wp_rdata) ? tp_rdata - wp_rdata : wp_rdata - tp_rdata;
        d_edg = (te_rdata > we_rdata) ? te_rdata - we_rdata : we_rdata - te_rdata;
        sad_acc_next = (s_first_reg ? '0 : sad_acc_reg) + SUM_W'(d_pix);
        edg_acc_next = (s_first_reg ? '0 : edg_acc_reg) + SUM_W'(d_edg);
        mat_acc_next = (s_first_reg ? '0 : mat_acc_reg)
                       + MCNT_W'(tp_rdata == wp_rdata);
    end

    // main control
    logic [CW-1:0] e_row, e_col, e_m1;
    logic          e_bord, e_end_pix;
    int            tsat, rsat;
    always_comb
    begin
        state_next = state_reg;
        tm1_next = tm1_reg;
        wm1_next = wm1_reg;
        r2_next  = r2_reg;
        rng_next = rng_reg;
        row_next = row_reg;
        col_next = col_reg;
        ti_next  = ti_reg;
        tj_next  = tj_reg;
        dr_next  = dr_reg;
        dc_next  = dc_reg;

        e_vld_next  = 1'b0;
        e_win_next  = e_win_reg;
        e_tap_next  = e_tap_reg;
        e_last_next = e_last_reg;
        e_bord_next = e_bord_reg;
        e_dst_next  = e_dst_reg;

        s_vld_next   = 1'b0;
        s_first_next = s_first_reg;
        s_last_next  = s_last_reg;
        s_final_next = s_final_reg;
        s_dr_next    = s_dr_reg;
        s_dc_next    = s_dc_reg;

        cand_vld_next   = s_vld_reg && s_last_reg;
        cand_final_next = s_final_reg;
        cand_sad_next   = sad_acc_next;
        cand_edg_next   = edg_acc_next;
        cand_mat_next   = mat_acc_next;
        cand_dr_next    = s_dr_reg;
        cand_dc_next    = s_dc_reg;

        best_sad_next = best_sad_reg;
        best_edg_next = best_edg_reg;
        best_mat_next = best_mat_reg;
        best_dr_next  = best_dr_reg;
        best_dc_next  = best_dc_reg;

        done_next    = 1'b0;
        vr_next      = vr_reg;
        vc_next      = vc_reg;
        sad_out_next = sad_out_reg;
        edg_out_next = edg_out_reg;
        mat_out_next = mat_out_reg;

        tsat = int'(block_cfg_reg);
        if (tsat < 3)
        begin
            tsat = 3;
        end
        if (tsat > MAX_BLOCK)
        begin
            tsat = MAX_BLOCK;
        end
        rsat = (int'(range_cfg_reg) > MAX_RANGE) ? MAX_RANGE : int'(range_cfg_reg);

        e_m1      = (state_reg == ST_EDGE_W) ? wm1_reg : tm1_reg;
        e_row     = row_reg + CW'(ti_reg) - CW'(1);
        e_col     = col_reg + CW'(tj_reg) - CW'(1);
        e_bord    = (row_reg == '0) || (col_reg == '0) || (row_reg == e_m1)
                    || (col_reg == e_m1);
        e_end_pix = (ti_reg == 2'd2) && (tj_reg == 2'd2);

        tp_raddr = t_addr(e_row, e_col);
        wp_raddr = w_addr(e_row, e_col);
        te_raddr = t_addr(row_reg, col_reg);
        we_raddr = w_addr(dr_reg + row_reg, dc_reg + col_reg);

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (accept && last_pixel)
                begin
                    tm1_next = CW'(tsat - 1);
                    wm1_next = CW'(tsat + 2 * rsat - 1);
                    r2_next  = CW'(2 * rsat);
                    rng_next = CW'(rsat);
                    row_next = '0;
                    col_next = '0;
                    ti_next  = '0;
                    tj_next  = '0;
                    state_next = ST_EDGE_T;
                end
            end
            ST_EDGE_T, ST_EDGE_W:
            begin
                e_vld_next  = 1'b1;
                e_win_next  = (state_reg == ST_EDGE_W);
                e_tap_next  = TAP_W'(3 * int'(ti_reg) + int'(tj_reg));
                e_last_next = e_end_pix;
                e_bord_next = e_bord;
                e_dst_next  = (state_reg == ST_EDGE_W) ? w_addr(row_reg, col_reg)
                              : WA_W'(t_addr(row_reg, col_reg));
                if (tj_reg == 2'd2)
                begin
                    tj_next = '0;
                    if (ti_reg == 2'd2)
                    begin
                        ti_next = '0;
                        if (col_reg == e_m1)
                        begin
                            col_next = '0;
                            if (row_reg == e_m1)
                            begin
                                row_next   = '0;
                                state_next = (state_reg == ST_EDGE_T) ? ST_EDGE_W
                                             : ST_DRAIN;
                            end
                            else
                            begin
                                row_next = row_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ti_next = ti_reg + 2'd1;
                    end
                end
                else
                begin
                    tj_next = tj_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                row_next = '0;
                col_next = '0;
                dr_next  = '0;
                dc_next  = '0;
                best_sad_next = SUM_W'(17'h1FFFF);
                best_edg_next = SUM_W'(17'h1FFFF);
                best_mat_next = '0;
                best_dr_next  = rng_reg;
                best_dc_next  = rng_reg;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                tp_raddr = t_addr(row_reg, col_reg);
                wp_raddr = w_addr(dr_reg + row_reg, dc_reg + col_reg);
                s_vld_next   = 1'b1;
                s_first_next = (row_reg == '0) && (col_reg == '0);
                s_last_next  = (row_reg == tm1_reg) && (col_reg == tm1_reg);
                s_final_next = (row_reg == tm1_reg) && (col_reg == tm1_reg)
                               && (dr_reg == r2_reg) && (dc_reg == r2_reg);
                s_dr_next    = dr_reg;
                s_dc_next    = dc_reg;
                if (col_reg == tm1_reg)
                begin
                    col_next = '0;
                    if (row_reg == tm1_reg)
                    begin
                        row_next = '0;
                        if (dc_reg == r2_reg)
                        begin
                            dc_next = '0;
                            if (dr_reg == r2_reg)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                dr_next = dr_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            dc_next = dc_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        row_next = row_reg + CW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_FLUSH:
            begin
                if (cand_vld_reg && cand_final_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cand_vld_reg)
        begin
            if ((cand_sad_reg < best_sad_reg)
                || ((cand_sad_reg == best_sad_reg) && (cand_edg_reg > best_edg_reg)))
            begin
                best_sad_next = cand_sad_reg;
                best_edg_next = cand_edg_reg;
                best_mat_next = cand_mat_reg;
                best_dr_next  = cand_dr_reg;
                best_dc_next  = cand_dc_reg;
            end
            if (cand_final_reg)
            begin
                done_next    = 1'b1;
                vr_next      = VEC_W'(best_dr_next - rng_reg);
                vc_next      = VEC_W'(best_dc_next - rng_reg);
                sad_out_next = (best_sad_next > SUM_W'(16'hFFFF)) ? 16'hFFFF
                               : COST_W'(best_sad_next);
                edg_out_next = (best_edg_next > SUM_W'(16'hFFFF)) ? 16'hFFFF
                               : COST_W'(best_edg_next);
                mat_out_next = (int'(best_mat_next) > 511) ? 9'h1FF
                               : MATCH_W'(best_mat_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_cfg_reg <= RANGE_W'(4);
            block_cfg_reg <= BLOCK_W'(16);
            kernel_reg    <= '0;
            e_vld_reg     <= 1'b0;
            s_vld_reg     <= 1'b0;
            cand_vld_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            e_vld_reg    <= e_vld_next;
            s_vld_reg    <= s_vld_next;
            cand_vld_reg <= cand_vld_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RANGE:  range_cfg_reg <= cfg_data[RANGE_W-1:0];
                    CFG_BLOCK:  block_cfg_reg <= cfg_data[BLOCK_W-1:0];
                    CFG_KERNEL: kernel_reg    <= cfg_data[KERNEL_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tm1_reg <= tm1_next;
        wm1_reg <= wm1_next;
        r2_reg  <= r2_next;
        rng_reg <= rng_next;
        row_reg <= row_next;
        col_reg <= col_next;
        ti_reg  <= ti_next;
        tj_reg  <= tj_next;
        dr_reg  <= dr_next;
        dc_reg  <= dc_next;

        e_win_reg  <= e_win_next;
        e_tap_reg  <= e_tap_next;
        e_last_reg <= e_last_next;
        e_bord_reg <= e_bord_next;
        e_dst_reg  <= e_dst_next;
        if (e_vld_reg)
        begin
            acc_reg <= acc_next;
        end

        s_first_reg <= s_first_next;
        s_last_reg  <= s_last_next;
        s_final_reg <= s_final_next;
        s_dr_reg    <= s_dr_next;
        s_dc_reg    <= s_dc_next;
        if (s_vld_reg)
        begin
            sad_acc_reg <= sad_acc_next;
            edg_acc_reg <= edg_acc_next;
            mat_acc_reg <= mat_acc_next;
        end

        cand_final_reg <= cand_final_next;
        cand_sad_reg   <= cand_sad_next;
        cand_edg_reg   <= cand_edg_next;
        cand_mat_reg   <= cand_mat_next;
        cand_dr_reg    <= cand_dr_next;
        cand_dc_reg    <= cand_dc_next;

        best_sad_reg <= best_sad_next;
        best_edg_reg <= best_edg_next;
        best_mat_reg <= best_mat_next;
        best_dr_reg  <= best_dr_next;
        best_dc_reg  <= best_dc_next;

        vr_reg      <= vr_next;
        vc_reg      <= vc_next;
        sad_out_reg <= sad_out_next;
        edg_out_reg <= edg_out_next;
        mat_out_reg <= mat_out_next;
    end

    assign done        = done_reg;
    assign vec_row     = $signed(vr_reg);
    assign vec_col     = $signed(vc_reg);
    assign sad_cost    = sad_out_reg;
    assign edge_cost   = edg_out_reg;
    assign match_count = mat_out_reg;

endmodule
